### sv/tcw_pkg.sv
// Shared constants, types and the address helper for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int OP_W           = 2;
    localparam int CHAR_W         = 8;
    localparam int ATTR_W         = 8;
    localparam int CELL_INDEX_W   = 11;
    localparam int CURSOR_CELL_W  = 11;
    localparam int CELL_W         = CHAR_W + ATTR_W;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CUR_W  = $clog2(CELL_COUNT + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int SUM_W  = ((ADDR_W > CELL_INDEX_W) ? ADDR_W : CELL_INDEX_W) + 1;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [ATTR_W-1:0] BLANK_ATTR   = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL   = {BLANK_ATTR, BLANK_CHAR};

    // cursor value right after a scroll, as seen on the result port
    localparam logic [CURSOR_CELL_W-1:0] SCROLL_CURSOR =
        CURSOR_CELL_W'(CELL_COUNT - COLUMNS);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // Screen rows are kept in a ring; off is the physical start of the top row.
    function automatic logic [ADDR_W-1:0] phys_addr(input logic [SUM_W-1:0] logical,
                                                    input logic [ADDR_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = logical + SUM_W'(off);
        if (sum >= SUM_W'(CELL_COUNT)) begin
            sum = sum - SUM_W'(CELL_COUNT);
        end
        return ADDR_W'(sum);
    endfunction

endpackage

### sv/tcw_cell_ram.sv
// Character cell store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module tcw_cell_ram
    import tcw_pkg::*;
(
    input  logic              aclk,
    input  ram_req_t          req,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/tcw_ctrl.sv
// Sequencer: cursor, row ring offset, blanking sweeps and the result register.
`timescale 1ns / 1ps

module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          op,
    input  logic [CHAR_W-1:0]        char_code,
    input  logic [ATTR_W-1:0]        attribute,
    input  logic [CELL_INDEX_W-1:0]  cell_index,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [CURSOR_CELL_W-1:0] cursor_cell,
    output logic [CHAR_W-1:0]        read_char,
    output logic [ATTR_W-1:0]        read_attribute,
    output logic                     did_scroll,
    output ram_req_t                 ram_req,
    input  logic [CELL_W-1:0]        ram_rdata
);

    typedef enum logic [2:0] {
        ST_SWEEP  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] top_off_reg, top_off_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0] sweep_last_reg, sweep_last_next;
    logic              sweep_pend_reg, sweep_pend_next;
    logic              res_scroll_reg, res_scroll_next;
    logic              res_read_reg, res_read_next;

    logic                     m_valid_reg, m_valid_next;
    logic [CURSOR_CELL_W-1:0] m_cursor_reg, m_cursor_next;
    logic [CHAR_W-1:0]        m_char_reg, m_char_next;
    logic [ATTR_W-1:0]        m_attr_reg, m_attr_next;
    logic                     m_scroll_reg, m_scroll_next;

    logic              accept;
    logic              out_free;
    logic              is_nl;
    logic [CUR_W:0]    cur_adv;
    logic              wrap;
    logic              in_range;
    logic [ADDR_W:0]   top_off_inc;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_nl    = (char_code == NEWLINE_CHAR);

    // newline jumps to the next multiple of COLUMNS
    assign cur_adv = is_nl ? ((CUR_W+1)'(cursor_reg) + (CUR_W+1)'(COLUMNS) - (CUR_W+1)'(col_reg))
                           : ((CUR_W+1)'(cursor_reg) + (CUR_W+1)'(1));
    assign wrap     = (cur_adv == (CUR_W+1)'(CELL_COUNT));
    assign in_range = ((SUM_W)'(cell_index) < SUM_W'(CELL_COUNT));
    assign top_off_inc = (ADDR_W+1)'(top_off_reg) + (ADDR_W+1)'(COLUMNS);

    always_comb begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        top_off_next    = top_off_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        sweep_pend_next = sweep_pend_reg;
        res_scroll_next = res_scroll_reg;
        res_read_next   = res_read_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_cursor_next   = m_cursor_reg;
        m_char_next     = m_char_reg;
        m_attr_next     = m_attr_reg;
        m_scroll_next   = m_scroll_reg;

        ram_req       = '0;
        ram_req.waddr = phys_addr(SUM_W'(cursor_reg), top_off_reg);
        ram_req.wdata = {attribute, char_code};
        ram_req.raddr = phys_addr(SUM_W'(cell_index), top_off_reg);

        unique case (state_reg)
            ST_SWEEP: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = sweep_addr_reg;
                ram_req.wdata = BLANK_CELL;
                if (sweep_addr_reg == sweep_last_reg) begin
                    sweep_pend_next = 1'b0;
                    state_next      = ST_IDLE;
                end else begin
                    sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    res_scroll_next = 1'b0;
                    res_read_next   = 1'b0;
                    state_next      = ST_RESULT;
                    unique case (op)
                        OP_WRITE: begin
                            ram_req.we = !is_nl;
                            if (is_nl || col_reg == COL_W'(COLUMNS - 1)) begin
                                col_next = '0;
                            end else begin
                                col_next = col_reg + COL_W'(1);
                            end
                            if (wrap) begin
                                // drop the top row: the old top becomes the new bottom
                                cursor_next     = CUR_W'(cur_adv - (CUR_W+1)'(COLUMNS));
                                top_off_next    = (top_off_inc == (ADDR_W+1)'(CELL_COUNT)) ?
                                                  '0 : ADDR_W'(top_off_inc);
                                sweep_addr_next = top_off_reg;
                                sweep_last_next = ADDR_W'(top_off_inc - (ADDR_W+1)'(1));
                                sweep_pend_next = 1'b1;
                                res_scroll_next = 1'b1;
                            end else begin
                                cursor_next = CUR_W'(cur_adv);
                            end
                        end
                        OP_CLEAR: begin
                            cursor_next     = '0;
                            col_next        = '0;
                            top_off_next    = '0;
                            sweep_addr_next = '0;
                            sweep_last_next = ADDR_W'(CELL_COUNT - 1);
                            sweep_pend_next = 1'b1;
                        end
                        OP_READ: begin
                            ram_req.re    = in_range;
                            res_read_next = in_range;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_cursor_next = CURSOR_CELL_W'(cursor_reg);
                    m_char_next   = res_read_reg ? ram_rdata[CHAR_W-1:0] : '0;
                    m_attr_next   = res_read_reg ? ram_rdata[CELL_W-1:CHAR_W] : '0;
                    m_scroll_next = res_scroll_reg;
                    state_next    = sweep_pend_reg ? ST_SWEEP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            cursor_reg     <= '0;
            col_reg        <= '0;
            top_off_reg    <= '0;
            sweep_addr_reg <= '0;
            sweep_last_reg <= ADDR_W'(CELL_COUNT - 1);
            sweep_pend_reg <= 1'b1;
            res_scroll_reg <= 1'b0;
            res_read_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            col_reg        <= col_next;
            top_off_reg    <= top_off_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            sweep_pend_reg <= sweep_pend_next;
            res_scroll_reg <= res_scroll_next;
            res_read_reg   <= res_read_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_cursor_reg <= m_cursor_next;
        m_char_reg   <= m_char_next;
        m_attr_reg   <= m_attr_next;
        m_scroll_reg <= m_scroll_next;
    end

    assign m_valid        = m_valid_reg;
    assign cursor_cell    = m_cursor_reg;
    assign read_char      = m_char_reg;
    assign read_attribute = m_attr_reg;
    assign did_scroll     = m_scroll_reg;

endmodule

### sv/text_console_writer.sv
// Top level of the text console writer: stream ports, sequencer and cell store.
`timescale 1ns / 1ps

// Text console of ROWS x COLUMNS cells (25 x 80) with a cursor; every input
// word yields exactly one result word. Rows live in a ring inside a single
// port-pair RAM, so a scroll moves no data: the ring start advances one row
// and only the new bottom row is blanked. A write, newline, read or no-op
// is accepted in the idle state, which also issues the registered RAM read;
// the result state then loads the result register once the output is free.
// s_tready drops meanwhile, and a new word is taken while the previous result
// still waits. A scroll then blanks the COLUMNS cells of the new bottom row
// and a clear all ROWS*COLUMNS cells, through the RAM's one write port at one
// cell a cycle. After reset a clearing pass over all ROWS*COLUMNS cells (2000)
// runs with s_tready low.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // char_code[7:0], attribute[15:8], cell_index[26:16], zeros
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // cursor_cell[10:0], read_char[18:11],
                                   // read_attribute[26:19], did_scroll[27], zeros
);

    ram_req_t                 ram_req;
    logic [CELL_W-1:0]        ram_rdata;
    logic [CURSOR_CELL_W-1:0] cursor_cell;
    logic [CHAR_W-1:0]        read_char;
    logic [ATTR_W-1:0]        read_attribute;
    logic                     did_scroll;

    tcw_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_tvalid),
        .s_ready        (s_tready),
        .op             (s_tuser),
        .char_code      (s_tdata[7:0]),
        .attribute      (s_tdata[15:8]),
        .cell_index     (s_tdata[26:16]),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .cursor_cell    (cursor_cell),
        .read_char      (read_char),
        .read_attribute (read_attribute),
        .did_scroll     (did_scroll),
        .ram_req        (ram_req),
        .ram_rdata      (ram_rdata)
    );

    tcw_cell_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign m_tdata = {4'b0, did_scroll, read_attribute, read_char, cursor_cell};

endmodule

### sv/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
`timescale 1ns / 1ps

module tcw_checker
    import tcw_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // the clearing pass after reset keeps intake closed
    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    // one word at a time: intake closes after each accepted word
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted back to back");

    // a scroll always leaves the cursor at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[27] |-> m_tdata[10:0] == SCROLL_CURSOR)
        else $error("scroll left cursor off the bottom row start");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

### tb/tb.sv
// Self-checking stream testbench for the text console writer: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
    import tcw_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 12000;  // reset clear + screen clear + longest stall, with margin
    localparam int RANDOM_ITEMS = 1600;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [CURSOR_CELL_W-1:0] cursor;
        logic [CHAR_W-1:0]        rchar;
        logic [ATTR_W-1:0]        rattr;
        logic                     scrolled;
    } console_result_t;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic [CHAR_W-1:0]       ch;
        logic [ATTR_W-1:0]       attr;
        logic [CELL_INDEX_W-1:0] idx;
        bit                      typed;
        console_result_t         want;
    } console_cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;  // char_code[7:0], attribute[15:8], cell_index[26:16], zeros
    logic [1:0]  s_tuser = '0;  // op[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;       // cursor_cell[10:0], read_char[18:11],
                                // read_attribute[26:19], did_scroll[27], zeros

    text_console_writer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // shadow copy of the screen and cursor
    logic [CELL_W-1:0] shadow_cells [CELL_COUNT];
    int unsigned       shadow_cursor;

    console_result_t expected_results [$];
    int              mismatch_count = 0;
    bit              quiet = 1'b0;
    int              ready_hold = 0;
    int              idle_cycles = 0;

    function automatic void blank_screen();
        for (int i = 0; i < CELL_COUNT; i++) begin
            shadow_cells[i] = BLANK_CELL;
        end
        shadow_cursor = 0;
    endfunction

    function automatic console_result_t console_predict(logic [OP_W-1:0] op,
                                                        logic [CHAR_W-1:0] ch,
                                                        logic [ATTR_W-1:0] attr,
                                                        logic [CELL_INDEX_W-1:0] idx);
        console_result_t r;
        r = '0;
        case (op)
            OP_WRITE: begin
                if (ch == NEWLINE_CHAR) begin
                    shadow_cursor += COLUMNS - (shadow_cursor % COLUMNS);
                end else if (shadow_cursor < CELL_COUNT) begin
                    shadow_cells[shadow_cursor] = {attr, ch};
                    shadow_cursor++;
                end
                if (shadow_cursor >= CELL_COUNT) begin
                    for (int i = 0; i + COLUMNS < CELL_COUNT; i++) begin
                        shadow_cells[i] = shadow_cells[i + COLUMNS];
                    end
                    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
                        shadow_cells[i] = BLANK_CELL;
                    end
                    shadow_cursor -= COLUMNS;
                    r.scrolled = 1'b1;
                end
            end
            OP_CLEAR: begin
                blank_screen();
            end
            OP_READ: begin
                if (idx < CELL_COUNT) begin
                    r.rchar = shadow_cells[idx][CHAR_W-1:0];
                    r.rattr = shadow_cells[idx][CELL_W-1:CHAR_W];
                end
            end
            default: begin
            end
        endcase
        r.cursor = shadow_cursor[CURSOR_CELL_W-1:0];
        return r;
    endfunction

    // mostly short gaps, a few long ones, none in quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic report(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("tb: mismatch %s: got %0h, want %0h", what, got, want);
        end
    endtask

    task automatic send_word(input console_cmd_t cmd);
        int gap;
        console_result_t r;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd.op;
        s_tdata  <= {5'd0, cmd.idx, cmd.attr, cmd.ch};
        do @(posedge aclk); while (!s_tready);
        r = console_predict(cmd.op, cmd.ch, cmd.attr, cmd.idx);
        expected_results.push_back(cmd.typed ? cmd.want : r);
    endtask

    // hold off the sender until every outstanding word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    function automatic console_cmd_t row_typed(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                               logic [ATTR_W-1:0] attr,
                                               logic [CELL_INDEX_W-1:0] idx,
                                               int cur, logic [CHAR_W-1:0] rc,
                                               logic [ATTR_W-1:0] ra);
        console_cmd_t c;
        c.op = op; c.ch = ch; c.attr = attr; c.idx = idx; c.typed = 1'b1;
        c.want.cursor = cur[CURSOR_CELL_W-1:0];
        c.want.rchar = rc;
        c.want.rattr = ra;
        c.want.scrolled = 1'b0;
        return c;
    endfunction

    function automatic console_cmd_t row_model(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                               logic [ATTR_W-1:0] attr,
                                               logic [CELL_INDEX_W-1:0] idx);
        console_cmd_t c;
        c.op = op; c.ch = ch; c.attr = attr; c.idx = idx; c.typed = 1'b0;
        c.want = '0;
        return c;
    endfunction

    // receiver back-pressure
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(4, 0) == 0) begin
            ready_hold <= pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        console_result_t got;
        console_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.cursor   = m_tdata[10:0];
            got.rchar    = m_tdata[18:11];
            got.rattr    = m_tdata[26:19];
            got.scrolled = m_tdata[27];
            if (expected_results.size() == 0) begin
                report("word with nothing expected, cursor", int'(got.cursor), 0);
            end else begin
                want = expected_results.pop_front();
                if (got.cursor !== want.cursor) begin
                    report("cursor_cell", int'(got.cursor), int'(want.cursor));
                end
                if (got.rchar !== want.rchar) begin
                    report("read_char", int'(got.rchar), int'(want.rchar));
                end
                if (got.rattr !== want.rattr) begin
                    report("read_attribute", int'(got.rattr), int'(want.rattr));
                end
                if (got.scrolled !== want.scrolled) begin
                    report("did_scroll", int'(got.scrolled), int'(want.scrolled));
                end
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        console_cmd_t directed [$];
        console_cmd_t cmd;
        int sent;
        int next_toggle;
        int next_drain;
        int nl_pct;
        int burst;
        int r;
        int lo;
        int hi;

        blank_screen();

        // after reset every cell is blank and the cursor is home
        directed.push_back(row_typed(OP_READ, 8'h00, 8'h00, 11'd0, 0, BLANK_CHAR, BLANK_ATTR));
        directed.push_back(row_typed(OP_READ, 8'h00, 8'h00, 11'd1999, 0, BLANK_CHAR,
                                     BLANK_ATTR));
        // out-of-range reads give zeros
        directed.push_back(row_typed(OP_READ, 8'hFF, 8'hFF, 11'd2047, 0, 8'h00, 8'h00));
        directed.push_back(row_typed(OP_READ, 8'h00, 8'h00, 11'd2000, 0, 8'h00, 8'h00));
        // unused op changes nothing
        directed.push_back(row_typed(OP_UNUSED, 8'hFF, 8'hFF, 11'h7FF, 0, 8'h00, 8'h00));
        directed.push_back(row_typed(OP_WRITE, 8'hFF, 8'hFF, 11'h7FF, 1, 8'h00, 8'h00));
        directed.push_back(row_typed(OP_WRITE, 8'h00, 8'h00, 11'd0, 2, 8'h00, 8'h00));
        directed.push_back(row_typed(OP_READ, 8'h00, 8'h00, 11'd0, 2, 8'hFF, 8'hFF));
        directed.push_back(row_typed(OP_READ, 8'h00, 8'h00, 11'd1, 2, 8'h00, 8'h00));
        // newline is never stored
        directed.push_back(row_typed(OP_WRITE, NEWLINE_CHAR, 8'h5A, 11'd0, 80, 8'h00, 8'h00));
        directed.push_back(row_typed(OP_READ, 8'h00, 8'h00, 11'd2, 80, BLANK_CHAR, BLANK_ATTR));
        directed.push_back(row_typed(OP_WRITE, 8'h41, 8'h1E, 11'd0, 81, 8'h00, 8'h00));
        directed.push_back(row_typed(OP_READ, 8'h00, 8'h00, 11'd80, 81, 8'h41, 8'h1E));
        directed.push_back(row_model(OP_WRITE, 8'h09, 8'h80, 11'h2AA));
        directed.push_back(row_model(OP_WRITE, 8'h0B, 8'h01, 11'h555));
        directed.push_back(row_typed(OP_WRITE, NEWLINE_CHAR, 8'h00, 11'd0, 160, 8'h00, 8'h00));
        directed.push_back(row_model(OP_READ, 8'h00, 8'h00, 11'd81));
        // clear with a newline code in the data
        directed.push_back(row_typed(OP_CLEAR, NEWLINE_CHAR, 8'hFF, 11'h7FF, 0, 8'h00, 8'h00));
        directed.push_back(row_typed(OP_READ, 8'h00, 8'h00, 11'd80, 0, BLANK_CHAR, BLANK_ATTR));
        directed.push_back(row_typed(OP_READ, 8'h00, 8'h00, 11'd0, 0, BLANK_CHAR, BLANK_ATTR));
        directed.push_back(row_model(OP_WRITE, 8'h55, 8'hAA, 11'h555));
        directed.push_back(row_model(OP_READ, 8'hAA, 8'h55, 11'd0));
        directed.push_back(row_model(OP_UNUSED, 8'h00, 8'h00, 11'd0));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            send_word(directed[i]);
        end
        drain_results();

        sent = 0;
        next_toggle = $urandom_range(250, 80);
        next_drain = $urandom_range(500, 300);
        nl_pct = 12;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= next_toggle) begin
                quiet <= !quiet;
                next_toggle = sent + $urandom_range(250, 80);
                // 0% phases run lines off the right edge of the bottom row
                r = $urandom_range(2, 0);
                nl_pct = (r == 0) ? 0 : (r == 1) ? 3 : 15;
            end
            if (sent >= next_drain) begin
                drain_results();
                next_drain = sent + $urandom_range(500, 300);
            end
            cmd = row_model(OP_WRITE, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                            11'($urandom_range(2047, 0)));
            r = $urandom_range(999, 0);
            if (r < 3) begin
                cmd.op = OP_CLEAR;
            end else if (r < 20) begin
                cmd.op = OP_UNUSED;
            end else if (r < 30) begin
                // run of newlines to reach the bottom row quickly
                burst = $urandom_range(30, 1);
                cmd.ch = NEWLINE_CHAR;
                repeat (burst) begin
                    cmd.attr = 8'($urandom_range(255, 0));
                    send_word(cmd);
                end
                sent += burst;
                continue;
            end else if (r < 230) begin
                cmd.op = OP_READ;
                r = $urandom_range(99, 0);
                if (r < 10) begin
                    cmd.idx = 11'($urandom_range(2047, CELL_COUNT));
                end else if (r < 50) begin
                    lo = (shadow_cursor > 2 * COLUMNS) ? shadow_cursor - 2 * COLUMNS : 0;
                    hi = (shadow_cursor + COLUMNS < CELL_COUNT) ? shadow_cursor + COLUMNS
                                                                : CELL_COUNT - 1;
                    cmd.idx = 11'($urandom_range(hi, lo));
                end else begin
                    cmd.idx = 11'($urandom_range(CELL_COUNT - 1, 0));
                end
            end else if ($urandom_range(99, 0) < nl_pct) begin
                cmd.ch = NEWLINE_CHAR;
            end
            send_word(cmd);
            sent++;
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
